@@ hw/rtl/dcmma_pkg.sv @@
// shared types and constants for the dual channel min/max and moving average block
// no dependencies; imported by dcmma_ctrl, dcmma_dp and the top level

package dcmma_pkg;

    // field widths
    localparam int SOC_W  = 10;
    localparam int TEMP_W = 12;

    // default window length
    localparam int WINDOW_DEF = 5;

    // reset values of the running extremes
    localparam logic [SOC_W-1:0]         SOC_LOW_RST   = 10'd1000;
    localparam logic [SOC_W-1:0]         SOC_HIGH_RST  = 10'd0;
    localparam logic signed [TEMP_W-1:0] TEMP_LOW_RST  = 12'sd2047;
    localparam logic signed [TEMP_W-1:0] TEMP_HIGH_RST = -12'sd2048;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic update;
        logic div_init;
        logic div_step;
        logic out_load;
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic out_free;
    } status_t;

endpackage

@@ hw/rtl/dcmma_ctrl.sv @@
// controller state machine: sequences capture, update, division and result load
// depends on dcmma_pkg for the command and status types

module dcmma_ctrl #(
    parameter int WINDOW = dcmma_pkg::WINDOW_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  dcmma_pkg::status_t status,
    output dcmma_pkg::cmd_t   cmd
);
    import dcmma_pkg::*;

    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int DIV_W  = TEMP_W + CNT_W;
    localparam int STEP_W = $clog2(DIV_W);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIV_W - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_DIV_INIT,
        ST_DIVIDE,
        ST_FINISH
    } state_t;

    state_t              state_reg;
    logic [STEP_W-1:0]   step_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        state_reg <= ST_UPDATE;
                    end
                end
                ST_UPDATE: begin
                    state_reg <= ST_DIV_INIT;
                end
                ST_DIV_INIT: begin
                    step_reg  <= '0;
                    state_reg <= ST_DIVIDE;
                end
                ST_DIVIDE: begin
                    step_reg <= step_reg + STEP_W'(1);
                    if (step_reg == STEP_LAST) begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    if (status.out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        cmd          = '0;
        cmd.load     = (state_reg == ST_IDLE) && s_valid;
        cmd.update   = (state_reg == ST_UPDATE);
        cmd.div_init = (state_reg == ST_DIV_INIT);
        cmd.div_step = (state_reg == ST_DIVIDE);
        cmd.out_load = (state_reg == ST_FINISH) && status.out_free;
    end

    assign s_ready = (state_reg == ST_IDLE);

`ifndef ASSERT_OFF
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while an item is in progress");

    a_one_command: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(cmd))
        else $error("more than one datapath command at once");

    a_load_needs_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> status.out_free)
        else $error("result register overwritten");
`endif

endmodule

@@ hw/rtl/dcmma_dp.sv @@
// datapath: extremes, sample window, running sums, bit-serial dividers, result register
// depends on dcmma_pkg for widths, reset values and command/status types

module dcmma_dp #(
    parameter int WINDOW = dcmma_pkg::WINDOW_DEF
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  dcmma_pkg::cmd_t                          cmd,
    output dcmma_pkg::status_t                       status,
    input  logic                                     s_new_set,
    input  logic        [dcmma_pkg::SOC_W-1:0]       s_soc_sample,
    input  logic signed [dcmma_pkg::TEMP_W-1:0]      s_temp_sample,
    input  logic                                     m_ready,
    output logic                                     m_valid,
    output logic        [dcmma_pkg::SOC_W-1:0]       m_soc_minimum,
    output logic        [dcmma_pkg::SOC_W-1:0]       m_soc_maximum,
    output logic signed [dcmma_pkg::TEMP_W-1:0]      m_temp_minimum,
    output logic signed [dcmma_pkg::TEMP_W-1:0]      m_temp_maximum,
    output logic        [dcmma_pkg::SOC_W-1:0]       m_soc_average,
    output logic signed [dcmma_pkg::TEMP_W-1:0]      m_temp_average
);
    import dcmma_pkg::*;

    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int SSUM_W = SOC_W + CNT_W;
    localparam int TSUM_W = TEMP_W + CNT_W;
    localparam int DIV_W  = TSUM_W;
    localparam int REM_W  = CNT_W + 1;
    localparam logic [CNT_W-1:0] FILL_MAX = CNT_W'(WINDOW);

    // captured sample
    logic                      new_reg;
    logic        [SOC_W-1:0]   soc_in_reg;
    logic signed [TEMP_W-1:0]  temp_in_reg;

    // set statistics
    logic        [SOC_W-1:0]   soc_lo_reg, soc_hi_reg;
    logic signed [TEMP_W-1:0]  temp_lo_reg, temp_hi_reg;
    logic        [CNT_W-1:0]   fill_reg;
    logic        [SSUM_W-1:0]  soc_sum_reg;
    logic signed [TSUM_W-1:0]  temp_sum_reg;
    logic        [SOC_W-1:0]   soc_win_reg  [WINDOW];
    logic signed [TEMP_W-1:0]  temp_win_reg [WINDOW];

    // dividers
    logic [DIV_W-1:0] sq_reg, tq_reg;
    logic [REM_W-1:0] srem_reg, trem_reg;
    logic             tneg_reg;

    // result register
    logic                      m_valid_reg;
    logic        [SOC_W-1:0]   soc_min_reg, soc_max_reg, soc_avg_reg;
    logic signed [TEMP_W-1:0]  temp_min_reg, temp_max_reg, temp_avg_reg;

    // update logic
    logic        [SOC_W-1:0]   soc_lo_base, soc_hi_base, soc_lo_next, soc_hi_next, soc_evict;
    logic signed [TEMP_W-1:0]  temp_lo_base, temp_hi_base, temp_lo_next, temp_hi_next;
    logic signed [TEMP_W-1:0]  temp_evict;
    logic        [CNT_W-1:0]   fill_base, fill_next;
    logic                      win_full;
    logic        [SSUM_W-1:0]  soc_sum_base, soc_sum_next;
    logic signed [TSUM_W-1:0]  temp_sum_base, temp_sum_next;

    always_comb begin
        soc_lo_base   = new_reg ? SOC_LOW_RST   : soc_lo_reg;
        soc_hi_base   = new_reg ? SOC_HIGH_RST  : soc_hi_reg;
        temp_lo_base  = new_reg ? TEMP_LOW_RST  : temp_lo_reg;
        temp_hi_base  = new_reg ? TEMP_HIGH_RST : temp_hi_reg;
        fill_base     = new_reg ? '0 : fill_reg;
        soc_sum_base  = new_reg ? '0 : soc_sum_reg;
        temp_sum_base = new_reg ? '0 : temp_sum_reg;

        soc_lo_next  = (soc_in_reg  < soc_lo_base)  ? soc_in_reg  : soc_lo_base;
        soc_hi_next  = (soc_in_reg  > soc_hi_base)  ? soc_in_reg  : soc_hi_base;
        temp_lo_next = (temp_in_reg < temp_lo_base) ? temp_in_reg : temp_lo_base;
        temp_hi_next = (temp_in_reg > temp_hi_base) ? temp_in_reg : temp_hi_base;

        // oldest sample leaves the sum once the window is full
        win_full   = (fill_base == FILL_MAX);
        soc_evict  = win_full ? soc_win_reg[WINDOW-1]  : '0;
        temp_evict = win_full ? temp_win_reg[WINDOW-1] : '0;

        soc_sum_next  = soc_sum_base + SSUM_W'(soc_in_reg) - SSUM_W'(soc_evict);
        temp_sum_next = temp_sum_base + TSUM_W'(temp_in_reg) - TSUM_W'(temp_evict);
        fill_next     = win_full ? fill_base : fill_base + CNT_W'(1);
    end

    // restoring division, one quotient bit per step
    logic [REM_W-1:0] s_trial, t_trial, divisor;
    logic             s_ge, t_ge;
    logic [DIV_W-1:0] temp_mag;

    always_comb begin
        divisor  = {1'b0, fill_reg};
        s_trial  = {srem_reg[REM_W-2:0], sq_reg[DIV_W-1]};
        t_trial  = {trem_reg[REM_W-2:0], tq_reg[DIV_W-1]};
        s_ge     = (s_trial >= divisor);
        t_ge     = (t_trial >= divisor);
        temp_mag = temp_sum_reg[TSUM_W-1] ? DIV_W'(-temp_sum_reg) : DIV_W'(temp_sum_reg);
    end

    logic        [TEMP_W-1:0] t_quot;
    logic signed [TEMP_W-1:0] temp_avg_next;

    always_comb begin
        t_quot        = tq_reg[TEMP_W-1:0];
        temp_avg_next = tneg_reg ? -$signed(t_quot) : $signed(t_quot);
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            new_reg     <= s_new_set;
            soc_in_reg  <= s_soc_sample;
            temp_in_reg <= s_temp_sample;
        end
        if (cmd.update) begin
            soc_win_reg[0]  <= soc_in_reg;
            temp_win_reg[0] <= temp_in_reg;
            for (int k = 1; k < WINDOW; k++) begin
                soc_win_reg[k]  <= soc_win_reg[k-1];
                temp_win_reg[k] <= temp_win_reg[k-1];
            end
        end
        if (cmd.div_init) begin
            sq_reg   <= DIV_W'(soc_sum_reg);
            tq_reg   <= temp_mag;
            tneg_reg <= temp_sum_reg[TSUM_W-1];
            srem_reg <= '0;
            trem_reg <= '0;
        end else if (cmd.div_step) begin
            sq_reg   <= {sq_reg[DIV_W-2:0], s_ge};
            tq_reg   <= {tq_reg[DIV_W-2:0], t_ge};
            srem_reg <= s_ge ? s_trial - divisor : s_trial;
            trem_reg <= t_ge ? t_trial - divisor : t_trial;
        end
        if (cmd.out_load) begin
            soc_min_reg  <= soc_lo_reg;
            soc_max_reg  <= soc_hi_reg;
            temp_min_reg <= temp_lo_reg;
            temp_max_reg <= temp_hi_reg;
            soc_avg_reg  <= sq_reg[SOC_W-1:0];
            temp_avg_reg <= temp_avg_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            soc_lo_reg   <= SOC_LOW_RST;
            soc_hi_reg   <= SOC_HIGH_RST;
            temp_lo_reg  <= TEMP_LOW_RST;
            temp_hi_reg  <= TEMP_HIGH_RST;
            fill_reg     <= '0;
            soc_sum_reg  <= '0;
            temp_sum_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cmd.update) begin
                soc_lo_reg   <= soc_lo_next;
                soc_hi_reg   <= soc_hi_next;
                temp_lo_reg  <= temp_lo_next;
                temp_hi_reg  <= temp_hi_next;
                fill_reg     <= fill_next;
                soc_sum_reg  <= soc_sum_next;
                temp_sum_reg <= temp_sum_next;
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign status.out_free = !m_valid_reg || m_ready;

    assign m_valid        = m_valid_reg;
    assign m_soc_minimum  = soc_min_reg;
    assign m_soc_maximum  = soc_max_reg;
    assign m_temp_minimum = temp_min_reg;
    assign m_temp_maximum = temp_max_reg;
    assign m_soc_average  = soc_avg_reg;
    assign m_temp_average = temp_avg_reg;

`ifndef ASSERT_OFF
    a_fill_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FILL_MAX)
        else $error("fill count beyond window length");

    a_divisor_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_step |-> fill_reg != '0)
        else $error("division by an empty window");

    a_remainder_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_step |-> (srem_reg < divisor) && (trem_reg < divisor))
        else $error("divider remainder out of range");
`endif

endmodule

@@ hw/rtl/dual_channel_minmax_moving_average.sv @@
// per sample: after the input transfer the controller runs the statistics update, the
//   divider set-up, one divide step per quotient bit and the result load, which waits
//   until the result register is free; s_ready stays low until that load is done
// the result register lets the next sample in while the previous result waits
// reset (aresetn, synchronous, active low): empty set, extremes at their start values,
//   fill count zero, no result pending; window contents stay unknown until written

module dual_channel_minmax_moving_average #(
    parameter int WINDOW = dcmma_pkg::WINDOW_DEF
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    // sample input channel
    input  logic                                     s_valid,
    output logic                                     s_ready,
    input  logic                                     s_new_set,
    input  logic        [dcmma_pkg::SOC_W-1:0]       s_soc_sample,
    input  logic signed [dcmma_pkg::TEMP_W-1:0]      s_temp_sample,
    // result channel
    output logic                                     m_valid,
    input  logic                                     m_ready,
    output logic        [dcmma_pkg::SOC_W-1:0]       m_soc_minimum,
    output logic        [dcmma_pkg::SOC_W-1:0]       m_soc_maximum,
    output logic signed [dcmma_pkg::TEMP_W-1:0]      m_temp_minimum,
    output logic signed [dcmma_pkg::TEMP_W-1:0]      m_temp_maximum,
    output logic        [dcmma_pkg::SOC_W-1:0]       m_soc_average,
    output logic signed [dcmma_pkg::TEMP_W-1:0]      m_temp_average
);
    import dcmma_pkg::*;

    // command and status between controller and datapath
    cmd_t    cmd;
    status_t status;

    // sequencer: capture, update statistics, divide, load result
    dcmma_ctrl #(
        .WINDOW (WINDOW)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // extremes, window shift line, running sums, dividers and result register
    dcmma_dp #(
        .WINDOW (WINDOW)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .s_new_set      (s_new_set),
        .s_soc_sample   (s_soc_sample),
        .s_temp_sample  (s_temp_sample),
        .m_ready        (m_ready),
        .m_valid        (m_valid),
        .m_soc_minimum  (m_soc_minimum),
        .m_soc_maximum  (m_soc_maximum),
        .m_temp_minimum (m_temp_minimum),
        .m_temp_maximum (m_temp_maximum),
        .m_soc_average  (m_soc_average),
        .m_temp_average (m_temp_average)
    );

endmodule
